// ===== hw/rtl/lcwd_pkg.sv =====
// Package for the leg contact window detector.
// Holds sizes, register codes, the controller command/status structs and the load decode.
// No dependencies.
package lcwd_pkg;

    localparam int LEGS       = 6;
    localparam int LOAD_W     = 11;
    localparam int MASK_W     = 6;
    localparam int MAX_H      = 8;
    localparam int H_W        = 4;
    localparam int DEPTH      = 2 * MAX_H + 1;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int DEC_W      = LOAD_W + 1;
    localparam int ACC_W      = 16;
    localparam int HIST_W     = LEGS * LOAD_W;
    localparam int APB_AW     = 3;
    localparam int APB_DW     = 32;
    localparam int IDX_W      = APB_AW - 2;

    localparam logic [LOAD_W-1:0] LOAD_MISS = LOAD_W'(1024);
    localparam logic [H_W-1:0]    H_RESET   = H_W'(2);

    // register indexes
    localparam logic [IDX_W-1:0] REG_HALF_WINDOW = IDX_W'(0);

    typedef struct packed {
        logic [LEGS-1:0][LOAD_W-1:0] load;
        logic [MASK_W-1:0]           mask;
    } t_sample;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [ADDR_W-1:0] raddr;
        logic              clr_acc;
        logic              acc_en;
        logic              load_out;
        logic              final_res;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_sts;

    // Words above 1024 are negative loads of magnitude (word - 1024).
    function automatic logic signed [DEC_W-1:0] decode_load(input logic [LOAD_W-1:0] w);
        logic signed [DEC_W-1:0] v;
        v = $signed({1'b0, w});
        if (w > LOAD_MISS) begin
            return $signed({1'b0, LOAD_MISS}) - v;
        end
        return v;
    endfunction

endpackage

// ===== hw/rtl/lcwd_in_if.sv =====
// Sample channel: valid/ready plus six raw load words, answered mask and end-of-run flag.
// Depends on nothing.
interface lcwd_in_if;
    logic        valid;
    logic        ready;
    logic [10:0] load_leg0;
    logic [10:0] load_leg1;
    logic [10:0] load_leg2;
    logic [10:0] load_leg3;
    logic [10:0] load_leg4;
    logic [10:0] load_leg5;
    logic [5:0]  answered_mask;
    logic        end_of_run;

    modport source (
        output valid, load_leg0, load_leg1, load_leg2, load_leg3, load_leg4, load_leg5,
        output answered_mask, end_of_run,
        input  ready
    );
    modport sink (
        input  valid, load_leg0, load_leg1, load_leg2, load_leg3, load_leg4, load_leg5,
        input  answered_mask, end_of_run,
        output ready
    );
endinterface

// ===== hw/rtl/lcwd_out_if.sv =====
// Result channel: valid/ready plus six contact flags and the final-result marker.
// Depends on nothing.
interface lcwd_out_if;
    logic valid;
    logic ready;
    logic contact_leg0;
    logic contact_leg1;
    logic contact_leg2;
    logic contact_leg3;
    logic contact_leg4;
    logic contact_leg5;
    logic final_result;

    modport source (
        output valid, contact_leg0, contact_leg1, contact_leg2, contact_leg3,
        output contact_leg4, contact_leg5, final_result,
        input  ready
    );
    modport sink (
        input  valid, contact_leg0, contact_leg1, contact_leg2, contact_leg3,
        input  contact_leg4, contact_leg5, final_result,
        output ready
    );
endinterface

// ===== hw/rtl/lcwd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lcwd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== hw/rtl/lcwd_cfg.sv =====
// APB register block: holds half_window and hands the clamped value to the controller.
// Depends on lcwd_pkg.
module lcwd_cfg (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [lcwd_pkg::APB_AW-1:0] paddr,
    input  logic [lcwd_pkg::APB_DW-1:0] pwdata,
    output logic [lcwd_pkg::APB_DW-1:0] prdata,
    output logic                       pready,
    output logic [lcwd_pkg::H_W-1:0]   o_h
);
    import lcwd_pkg::*;

    logic [H_W-1:0]   r_half;
    logic [IDX_W-1:0] w_idx;
    logic             w_wr;

    assign w_idx  = paddr[APB_AW-1:2];
    assign w_wr   = psel & penable & pwrite & (w_idx == REG_HALF_WINDOW);
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half <= H_RESET;
        end else if (w_wr) begin
            r_half <= pwdata[H_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (psel && w_idx == REG_HALF_WINDOW) begin
            prdata = APB_DW'(r_half);
        end
    end

    // values beyond the history depth act as the maximum
    assign o_h = (r_half > H_W'(MAX_H)) ? H_W'(MAX_H) : r_half;
endmodule

// ===== hw/rtl/lcwd_ctrl.sv =====
// Controller: run counters, history write pointer and the per-result window sequencer.
// Depends on lcwd_pkg.
module lcwd_ctrl (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    input  logic                     i_end_of_run,
    output logic                     o_ready,
    input  logic [lcwd_pkg::H_W-1:0] i_h,
    output lcwd_pkg::t_cmd           o_cmd,
    input  lcwd_pkg::t_sts           i_sts
);
    import lcwd_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SETUP = 3'd1;
    localparam logic [2:0] S_RD    = 3'd2;
    localparam logic [2:0] S_ACC   = 3'd3;
    localparam logic [2:0] S_LOAD  = 3'd4;

    localparam logic [CNT_W-1:0]  DEPTH_C = CNT_W'(DEPTH);
    localparam int                SUM_W   = ADDR_W + 1;

    logic [2:0]        r_state, n_state;
    logic [CNT_W-1:0]  r_seen, n_seen;
    logic [CNT_W-1:0]  r_pos, n_pos;
    logic [ADDR_W-1:0] r_wptr, n_wptr;
    logic              r_last, n_last;
    logic [H_W-1:0]    r_h, n_h;
    logic [CNT_W-1:0]  r_age, n_age;
    logic [CNT_W-1:0]  r_a, n_a;
    logic [CNT_W-1:0]  r_hi, n_hi;

    logic [CNT_W-1:0]  w_seen_inc, w_pos_inc, w_hx, w_lo, w_hi, w_top;
    logic [SUM_W-1:0]  w_asum;
    logic              w_accept;

    assign o_ready  = (r_state == S_IDLE);
    assign w_accept = i_valid & o_ready;

    assign w_seen_inc = (r_seen < DEPTH_C) ? r_seen + CNT_W'(1) : r_seen;
    assign w_pos_inc  = (r_pos < DEPTH_C) ? r_pos + CNT_W'(1) : r_pos;
    assign w_hx       = CNT_W'(r_h);

    // window bounds around the current centre age
    assign w_lo  = (r_age > w_hx) ? r_age - w_hx : '0;
    assign w_top = r_seen - CNT_W'(1);
    assign w_hi  = (r_age + w_hx > w_top) ? w_top : r_age + w_hx;

    // ring slot of age a: one behind the write pointer, minus a, modulo the depth
    always_comb begin
        w_asum = SUM_W'(r_wptr) + SUM_W'(DEPTH - 1) - SUM_W'(r_a);
        if (w_asum >= SUM_W'(DEPTH)) begin
            w_asum = w_asum - SUM_W'(DEPTH);
        end
    end

    always_comb begin
        n_state = r_state;
        n_seen  = r_seen;
        n_pos   = r_pos;
        n_wptr  = r_wptr;
        n_last  = r_last;
        n_h     = r_h;
        n_age   = r_age;
        n_a     = r_a;
        n_hi    = r_hi;
        o_cmd   = '0;
        o_cmd.waddr = r_wptr;
        o_cmd.raddr = w_asum[ADDR_W-1:0];

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    o_cmd.we = 1'b1;
                    n_wptr = (r_wptr == ADDR_W'(DEPTH - 1)) ? '0 : r_wptr + ADDR_W'(1);
                    n_seen = w_seen_inc;
                    n_last = i_end_of_run;
                    n_h    = i_h;
                    if (i_end_of_run) begin
                        n_age   = w_pos_inc - CNT_W'(1);
                        n_pos   = w_pos_inc;
                        n_state = S_SETUP;
                    end else if (w_pos_inc > CNT_W'(i_h)) begin
                        n_age   = CNT_W'(i_h);
                        n_pos   = CNT_W'(i_h);
                        n_state = S_SETUP;
                    end else begin
                        n_pos = w_pos_inc;
                    end
                end
            end
            S_SETUP: begin
                o_cmd.clr_acc = 1'b1;
                n_a     = w_lo;
                n_hi    = w_hi;
                n_state = S_RD;
            end
            S_RD: begin
                n_state = S_ACC;
            end
            S_ACC: begin
                o_cmd.acc_en = 1'b1;
                if (r_a == r_hi) begin
                    n_state = S_LOAD;
                end else begin
                    n_a     = r_a + CNT_W'(1);
                    n_state = S_RD;
                end
            end
            S_LOAD: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out  = 1'b1;
                    o_cmd.final_res = r_last && (r_age == '0);
                    if (r_last && r_age != '0) begin
                        n_age   = r_age - CNT_W'(1);
                        n_state = S_SETUP;
                    end else begin
                        if (r_last) begin
                            n_seen = '0;
                            n_pos  = '0;
                        end
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_seen  <= '0;
            r_pos   <= '0;
            r_wptr  <= '0;
            r_last  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_seen  <= n_seen;
            r_pos   <= n_pos;
            r_wptr  <= n_wptr;
            r_last  <= n_last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_h   <= n_h;
        r_age <= n_age;
        r_a   <= n_a;
        r_hi  <= n_hi;
    end
endmodule

// ===== hw/rtl/lcwd_dp.sv =====
// Datapath: load history RAM, six window accumulators and the result register.
// Depends on lcwd_pkg, lcwd_ram and lcwd_out_if.
module lcwd_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lcwd_pkg::t_sample i_smp,
    input  lcwd_pkg::t_cmd    i_cmd,
    output lcwd_pkg::t_sts    o_sts,
    lcwd_out_if.source        o_res
);
    import lcwd_pkg::*;

    logic [HIST_W-1:0]             w_wdata;
    logic [HIST_W-1:0]             w_rdata;
    logic signed [ACC_W-1:0]       r_acc [LEGS];
    logic [LEGS-1:0]               r_contact;
    logic                          r_final;
    logic                          r_out_vld;

    // an unanswered leg is stored as the missing-reply word
    always_comb begin
        for (int l = 0; l < LEGS; l++) begin
            w_wdata[l*LOAD_W +: LOAD_W] = i_smp.mask[l] ? i_smp.load[l] : LOAD_MISS;
        end
    end

    lcwd_ram #(
        .WIDTH (HIST_W),
        .DEPTH (DEPTH)
    ) u_hist (
        .i_clk   (i_clk),
        .i_we    (i_cmd.we),
        .i_waddr (i_cmd.waddr),
        .i_wdata (w_wdata),
        .i_raddr (i_cmd.raddr),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        for (int l = 0; l < LEGS; l++) begin
            if (i_cmd.clr_acc) begin
                r_acc[l] <= '0;
            end else if (i_cmd.acc_en) begin
                r_acc[l] <= r_acc[l] + ACC_W'(decode_load(w_rdata[l*LOAD_W +: LOAD_W]));
            end
        end
    end

    assign o_sts.out_free = !r_out_vld || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_vld <= 1'b1;
        end else if (o_res.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    // contact when the window sum is zero or negative
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            for (int l = 0; l < LEGS; l++) begin
                r_contact[l] <= r_acc[l][ACC_W-1] || (r_acc[l] == '0);
            end
            r_final <= i_cmd.final_res;
        end
    end

    assign o_res.valid        = r_out_vld;
    assign o_res.contact_leg0 = r_contact[0];
    assign o_res.contact_leg1 = r_contact[1];
    assign o_res.contact_leg2 = r_contact[2];
    assign o_res.contact_leg3 = r_contact[3];
    assign o_res.contact_leg4 = r_contact[4];
    assign o_res.contact_leg5 = r_contact[5];
    assign o_res.final_result = r_final;
endmodule

// ===== hw/rtl/leg_contact_window_detector.sv =====
// Top level of the leg contact window detector: config block, controller and datapath.
// Depends on lcwd_pkg, lcwd_in_if, lcwd_out_if, lcwd_cfg, lcwd_ctrl, lcwd_dp.
//
//   channel | dir | handshake            | payload
//   --------+-----+----------------------+------------------------------------------
//   i_smp   | in  | valid/ready          | load_leg0..5, answered_mask, end_of_run
//   o_res   | out | valid/ready          | contact_leg0..5, final_result
//   APB     | in  | psel/penable, pready | half_window at byte address 0
//
// Items are taken one at a time, only while the controller is idle.
// Each result sums a window of W samples (at most 2*half_window+1) from the history RAM,
// which is read once per sample with a registered read.
// An end-of-run item flushes every pending sample, at most MAX_H+1 results, one at a time.
// A result waiting on o_res stalls only the next result load; the next item is still taken.
// Reset is synchronous, active low; history contents are not cleared (run counters gate reads).
module leg_contact_window_detector (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    lcwd_in_if.sink                      i_smp,
    lcwd_out_if.source                   o_res,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [lcwd_pkg::APB_AW-1:0]  paddr,
    input  logic [lcwd_pkg::APB_DW-1:0]  pwdata,
    output logic [lcwd_pkg::APB_DW-1:0]  prdata,
    output logic                         pready
);
    import lcwd_pkg::*;

    logic [H_W-1:0] w_h;
    t_cmd           w_cmd;
    t_sts           w_sts;
    t_sample        w_sample;
    logic           w_ready;

    // gather the sample payload for the history write
    assign w_sample.load[0] = i_smp.load_leg0;
    assign w_sample.load[1] = i_smp.load_leg1;
    assign w_sample.load[2] = i_smp.load_leg2;
    assign w_sample.load[3] = i_smp.load_leg3;
    assign w_sample.load[4] = i_smp.load_leg4;
    assign w_sample.load[5] = i_smp.load_leg5;
    assign w_sample.mask    = i_smp.answered_mask;
    assign i_smp.ready      = w_ready;

    lcwd_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_h     (w_h)
    );

    lcwd_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_smp.valid),
        .i_end_of_run (i_smp.end_of_run),
        .o_ready      (w_ready),
        .i_h          (w_h),
        .o_cmd        (w_cmd),
        .i_sts        (w_sts)
    );

    lcwd_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_smp   (w_sample),
        .i_cmd   (w_cmd),
        .o_sts   (w_sts),
        .o_res   (o_res)
    );
endmodule
